// ----- hdl/utf8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, constants, types and the sequence decode function for the
// UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int ByteW  = 8;
   localparam int AvailW = 3;
   localparam int CpW    = 21;
   localparam int LenW   = 3;

   // req beat: byte0..byte3, avail, zero fill to whole bytes
   localparam int ReqDataW = 40;
   // rsp beat: codepoint, length
   localparam int RspDataW = 24;

   localparam logic [AvailW-1:0] AvailMax    = 3'd4;
   localparam logic [CpW-1:0]    Replacement = 21'h00FFFD;
   localparam logic [CpW-1:0]    SurrLow     = 21'h00D800;
   localparam logic [CpW-1:0]    SurrHigh    = 21'h00DFFF;
   localparam logic [ByteW-1:0]  ContLow     = 8'h80;
   localparam logic [ByteW-1:0]  ContHigh    = 8'hBF;
   localparam logic [ByteW-1:0]  ContMask    = 8'h3F;
   localparam logic [ByteW-1:0]  Lead2Mask   = 8'h1F;
   localparam logic [ByteW-1:0]  Lead3Mask   = 8'h0F;
   localparam logic [ByteW-1:0]  Lead4Mask   = 8'h07;

   localparam logic [LenW-1:0] Len0 = 3'd0;
   localparam logic [LenW-1:0] Len1 = 3'd1;
   localparam logic [LenW-1:0] Len2 = 3'd2;
   localparam logic [LenW-1:0] Len3 = 3'd3;
   localparam logic [LenW-1:0] Len4 = 3'd4;

   typedef struct packed {
      logic [ByteW-1:0]  byte0;
      logic [ByteW-1:0]  byte1;
      logic [ByteW-1:0]  byte2;
      logic [ByteW-1:0]  byte3;
      logic [AvailW-1:0] avail;
   } item_type;

   typedef struct packed {
      logic [CpW-1:0]  codepoint;
      logic [LenW-1:0] length;
      logic            error;
   } result_type;

   function automatic logic is_cont(input logic [ByteW-1:0] b);
      return (b >= ContLow) && (b <= ContHigh);
   endfunction

   function automatic result_type decode(input item_type it);
      result_type        res;
      logic [LenW-1:0]   len;
      logic [CpW-1:0]    cp;
      logic [AvailW-1:0] avail_sat;
      logic [ByteW-1:0]  m1;
      logic [ByteW-1:0]  m2;
      logic [ByteW-1:0]  m3;
      logic              bad;
      m1        = it.byte1 & ContMask;
      m2        = it.byte2 & ContMask;
      m3        = it.byte3 & ContMask;
      avail_sat = (it.avail > AvailMax) ? AvailMax : it.avail;
      bad       = 1'b0;
      case (it.byte0) inside
         [8'h00:8'h7F]: begin
            len = Len1;
            cp  = {13'd0, it.byte0};
         end
         [8'hC0:8'hDF]: begin
            len = Len2;
            cp  = {10'd0, it.byte0[4:0] & Lead2Mask[4:0], m1[5:0]};
         end
         [8'hE0:8'hEF]: begin
            len = Len3;
            cp  = {5'd0, it.byte0[3:0] & Lead3Mask[3:0], m1[5:0], m2[5:0]};
         end
         [8'hF0:8'hF7]: begin
            len = Len4;
            cp  = {it.byte0[2:0] & Lead4Mask[2:0], m1[5:0], m2[5:0], m3[5:0]};
         end
         default: begin
            // stray continuation or lead above 0xF7
            len = Len0;
            cp  = '0;
            bad = 1'b1;
         end
      endcase
      if ((avail_sat == '0) || (avail_sat < len)) bad = 1'b1;
      if ((cp >= SurrLow) && (cp <= SurrHigh)) bad = 1'b1;
      if ((len >= Len2) && !is_cont(it.byte1)) bad = 1'b1;
      if ((len >= Len3) && !is_cont(it.byte2)) bad = 1'b1;
      if ((len >= Len4) && !is_cont(it.byte3)) bad = 1'b1;
      if (bad) begin
         res.codepoint = Replacement;
         res.length    = Len0;
         res.error     = 1'b1;
      end else begin
         res.codepoint = cp;
         res.length    = len;
         res.error     = 1'b0;
      end
      return res;
   endfunction

endpackage

// ----- hdl/utf8_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder
// Decodes one UTF-8 sequence per request beat into a code point, its length
// and an error flag.
// ----------------------------------------------------------------------------
// Each request beat gives up to four bytes from the head of a buffer and a
// count of valid bytes (values above four count as four). One response beat
// comes back per request, passing through the input register and then the
// result register. A new beat is taken every cycle unless both registers hold
// a beat while the response side stalls; throughput is one item per clock,
// set by the two-register pipeline whose stages advance whenever the result
// register is empty or being read. Invalid sequences (empty or short buffer,
// bad lead, bad continuation, surrogate result) return code point 0xFFFD,
// length zero and tuser set. Overlong forms and leads 0xF5..0xF7 are decoded
// as their bits give.
module utf8_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24], avail [34:32]
   input  logic [utf8d_pkg::ReqDataW-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // codepoint [20:0], length [23:21]
   output logic [utf8d_pkg::RspDataW-1:0]    rsp_tdata,
   // error [0]
   output logic                              rsp_tuser
);
   import utf8d_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   in_item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type out_res_in;
   logic       advance;

   // result register free or draining this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_res_in   = decode(in_item_ff);
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in  = item_type'{
            byte0: req_tdata[7:0],
            byte1: req_tdata[15:8],
            byte2: req_tdata[23:16],
            byte3: req_tdata[31:24],
            avail: req_tdata[34:32]
         };
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_res_ff.length, out_res_ff.codepoint};
   assign rsp_tuser  = out_res_ff.error;

   // backpressure only when both registers hold a beat
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff))
      else $error("req_tready low with a free pipeline register");

   // an error beat carries the replacement code point and zero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[20:0] == Replacement && rsp_tdata[23:21] == Len0))
      else $error("error beat without replacement fields");

   // a good beat has a length of one to four
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tdata[23:21] != Len0 && rsp_tdata[23:21] <= Len4))
      else $error("good beat with bad length");

   // a held input beat moves on once the result register frees
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && !(req_tvalid && req_tready)) |=> out_valid_ff)
      else $error("input beat lost on advance");

endmodule

// ----- bench/utf8_decoder_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_chk
// Watches both streams of the UTF-8 decoder, decodes every accepted request
// beat on its own and compares each response beat, field by field, with the
// oldest decoded sequence still waiting.
// ----------------------------------------------------------------------------
module utf8_decoder_chk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24], avail [34:32]
   input  logic [utf8d_pkg::ReqDataW-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // codepoint [20:0], length [23:21]
   input  logic [utf8d_pkg::RspDataW-1:0] rsp_tdata,
   // error [0]
   input  logic                           rsp_tuser,
   output int                             errors,
   output int                             in_flight
);
   import utf8d_pkg::*;

   result_type decoded_q [$];

   initial begin
      errors    = 0;
      in_flight = 0;
   end

   function automatic result_type decode_sequence(input logic [ReqDataW-1:0] beat);
      logic [7:0]  lead;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [7:0]  c3;
      logic [2:0]  cnt;
      logic [2:0]  nb;
      logic [20:0] cp;
      logic        bad;
      result_type  r;
      lead = beat[7:0];
      c1   = beat[15:8];
      c2   = beat[23:16];
      c3   = beat[31:24];
      cnt  = beat[34:32];
      if (cnt > AvailMax) cnt = AvailMax;
      bad = 1'b0;
      cp  = '0;
      if (!lead[7]) begin
         nb = Len1;
         cp = {13'd0, lead};
      end else if (lead[7:5] == 3'b110) begin
         nb = Len2;
         cp = {10'd0, lead[4:0], c1[5:0]};
      end else if (lead[7:4] == 4'b1110) begin
         nb = Len3;
         cp = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
      end else if (lead[7:3] == 5'b11110) begin
         nb = Len4;
         cp = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
      end else begin
         nb  = Len0;
         bad = 1'b1;
      end
      if (cnt == '0 || cnt < nb) bad = 1'b1;
      if (cp >= SurrLow && cp <= SurrHigh) bad = 1'b1;
      // continuation bytes must look like 10xxxxxx
      if (nb >= Len2 && c1[7:6] != 2'b10) bad = 1'b1;
      if (nb >= Len3 && c2[7:6] != 2'b10) bad = 1'b1;
      if (nb >= Len4 && c3[7:6] != 2'b10) bad = 1'b1;
      r.codepoint = bad ? Replacement : cp;
      r.length    = bad ? Len0 : nb;
      r.error     = bad;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         decoded_q.delete();
      end else begin
         // pop before push: a response never belongs to a beat taken this edge
         if (rsp_tvalid && rsp_tready) begin
            got.codepoint = rsp_tdata[20:0];
            got.length    = rsp_tdata[23:21];
            got.error     = rsp_tuser;
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual cp %h len %0d err %0b",
                        $time, got.codepoint, got.length, got.error);
               errors++;
            end else begin
               want = decoded_q.pop_front();
               if (got.codepoint !== want.codepoint) begin
                  $display("%0t: codepoint mismatch, expected %h, actual %h",
                           $time, want.codepoint, got.codepoint);
                  errors++;
               end
               if (got.length !== want.length) begin
                  $display("%0t: length mismatch, expected %0d, actual %0d",
                           $time, want.length, got.length);
                  errors++;
               end
               if (got.error !== want.error) begin
                  $display("%0t: error flag mismatch, expected %0b, actual %0b",
                           $time, want.error, got.error);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) decoded_q.push_back(decode_sequence(req_tdata));
      end
      in_flight = decoded_q.size();
   end

endmodule

// ----- bench/utf8_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_tb
// Drives the UTF-8 decoder with directed sequences and then random ones,
// mostly well-formed with some corrupted, under three idle patterns on the
// request and response sides; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module utf8_decoder_tb;
   import utf8d_pkg::*;

   localparam int PhaseItems = 650;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tready;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int fails;
   int open_cnt;

   utf8_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   utf8_decoder_chk u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (fails),
      .in_flight  (open_cnt)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[utf8_decoder] ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [ReqDataW-1:0] beat_of(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] b3,
                                                   input logic [2:0] avail);
      return {5'd0, avail, b3, b2, b1, b0};
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer_beat(input logic [ReqDataW-1:0] beat);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [ReqDataW-1:0] make_sequence();
      logic [7:0] b [4];
      int         n;
      int         k;
      int         mode;
      logic [2:0] cnt;
      for (k = 0; k < 4; k++) b[k] = 8'($urandom);
      n = $urandom_range(1, 4);
      case (n)
         1: b[0] = 8'($urandom_range(8'h00, 8'h7F));
         2: b[0] = 8'($urandom_range(8'hC0, 8'hDF));
         3: b[0] = ($urandom_range(3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
         default: b[0] = 8'($urandom_range(8'hF0, 8'hF7));
      endcase
      for (k = 1; k < n; k++) b[k] = 8'($urandom_range(8'h80, 8'hBF));
      cnt = 3'(n);
      if ($urandom_range(3) == 0) cnt = 3'($urandom_range(n, 7));
      mode = $urandom_range(99);
      if (mode < 8) begin
         // pure noise
         for (k = 0; k < 4; k++) b[k] = 8'($urandom);
         cnt = 3'($urandom);
      end else if (mode < 14 && n > 1) begin
         k    = $urandom_range(1, n - 1);
         b[k] = ($urandom_range(1) == 0) ? 8'($urandom_range(8'h00, 8'h7F))
                                         : 8'($urandom_range(8'hC0, 8'hFF));
      end else if (mode < 18) begin
         cnt = 3'($urandom_range(0, n - 1));
      end else if (mode < 21) begin
         b[0] = ($urandom_range(1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                         : 8'($urandom_range(8'hF8, 8'hFF));
      end
      return beat_of(b[0], b[1], b[2], b[3], cnt);
   endfunction

   initial begin
      int k;
      send_gap_pct   = 32;
      recv_stall_pct = 85;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_beat(beat_of(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1));
      offer_beat(beat_of(8'h7F, 8'h00, 8'h00, 8'h00, 3'd1));
      offer_beat(beat_of(8'h00, 8'h00, 8'h00, 8'h00, 3'd0));  // empty buffer
      offer_beat(beat_of(8'hC2, 8'hA9, 8'h00, 8'h00, 3'd2));
      offer_beat(beat_of(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd2));
      offer_beat(beat_of(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2));  // overlong, accepted
      offer_beat(beat_of(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3));
      offer_beat(beat_of(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3));  // surrogate
      offer_beat(beat_of(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3));
      offer_beat(beat_of(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4));
      offer_beat(beat_of(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4));
      offer_beat(beat_of(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4));  // above the unicode range
      offer_beat(beat_of(8'h80, 8'h80, 8'h80, 8'h80, 3'd4));  // stray continuation lead
      offer_beat(beat_of(8'hBF, 8'h00, 8'h00, 8'h00, 3'd1));
      offer_beat(beat_of(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4));
      offer_beat(beat_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
      offer_beat(beat_of(8'hE2, 8'h82, 8'h00, 8'h00, 3'd2));  // short buffer
      offer_beat(beat_of(8'hF0, 8'h9F, 8'h98, 8'h00, 3'd3));
      offer_beat(beat_of(8'hC2, 8'h41, 8'h00, 8'h00, 3'd2));  // continuation too low
      offer_beat(beat_of(8'hC2, 8'hC0, 8'h00, 8'h00, 3'd2));  // continuation too high
      offer_beat(beat_of(8'hE2, 8'h82, 8'hFF, 8'h00, 3'd3));
      offer_beat(beat_of(8'hF0, 8'h9F, 8'h98, 8'h7F, 3'd4));
      offer_beat(beat_of(8'h41, 8'hFF, 8'hFF, 8'hFF, 3'd5));  // count saturates at four
      offer_beat(beat_of(8'hC2, 8'hA9, 8'h00, 8'h00, 3'd6));
      offer_beat(beat_of(8'hF0, 8'h90, 8'h80, 8'h80, 3'd7));

      // hold off until the pipeline has drained completely
      req_tvalid <= 1'b0;
      while (open_cnt != 0) @(negedge clock);

      for (k = 0; k < PhaseItems; k++) offer_beat(make_sequence());
      send_gap_pct   = 85;
      recv_stall_pct = 32;
      for (k = 0; k < PhaseItems; k++) offer_beat(make_sequence());
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      for (k = 0; k < PhaseItems; k++) offer_beat(make_sequence());
      req_tvalid <= 1'b0;

      while (open_cnt != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fails == 0) begin
         $display("[utf8_decoder] OK");
      end else begin
         $display("[utf8_decoder] ERROR");
      end
      $finish;
   end

endmodule
